// ===== src/nmf_pkg.sv =====
// nmf_pkg: shared constants and types for the neighbour mean filter
// no dependencies
`default_nettype none
package nmf_pkg;
    localparam int MAX_COLS = 32;
    localparam int PIXEL_BITS = 16;
    localparam int FRACTION_BITS = 8;
    localparam int COL_W = 5;
    localparam int ROW_W = 12;
    localparam int ADDR_W = 7;
    localparam int SUM_W = PIXEL_BITS + 3;
    localparam int MEAN_W = 24;
    // reciprocal divide: floor(x / d) = (x * ceil(2^RECIP_BITS / d)) >> RECIP_BITS
    localparam int RECIP_BITS = 29;
    localparam int RECIP_W = 28;
    localparam int RECIP_SHIFT = RECIP_BITS - FRACTION_BITS;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((2 ** RECIP_BITS + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'((2 ** RECIP_BITS + 4) / 5);
    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    typedef struct packed {
        logic             start;
        logic [ROW_W-1:0] pr;
        logic [COL_W-1:0] pc;
        logic [1:0]       sa;
        logic [1:0]       sc;
        logic [1:0]       sb;
        logic [ROW_W:0]   rows;
        logic [COL_W:0]   cols;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_status;
endpackage
`default_nettype wire

// ===== src/neighbour_mean_filter_3x3.sv =====
// neighbour_mean_filter_3x3: top level joining controller and datapath
// depends on nmf_pkg, nmf_ctrl, nmf_datapath
// Each result is made in steps: the command is issued, line store reads
// gather the neighbours, the sum is divided by the neighbour count as a
// reciprocal multiply and the result register is loaded. A pixel that
// causes no result does not stall the input; a pixel that causes n results
// holds the input stalled after it is taken until the last of them is loaded,
// longer while the output is stalled. The last pixel of a frame issues the
// whole last row, one result after another.
`default_nettype none
module neighbour_mean_filter_3x3 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_pixel,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [23:0]      o_mean_value,
    output logic [11:0]      o_out_row,
    output logic [4:0]       o_out_col,
    output logic [3:0]       o_neighbour_count,
    output logic             o_last_of_run,
    output logic             o_end_of_frame
);
    logic w_wr;
    logic [nmf_pkg::ADDR_W-1:0] w_addr;
    logic [nmf_pkg::PIXEL_BITS-1:0] w_data;
    nmf_pkg::t_cmd w_cmd;
    nmf_pkg::t_status w_status;

    nmf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_pixel,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_wr(w_wr), .o_wr_addr(w_addr), .o_wr_data(w_data),
        .o_cmd(w_cmd), .i_status(w_status)
    );

    nmf_datapath u_dp (
        .i_clk, .i_rst_n, .i_wr(w_wr), .i_wr_addr(w_addr), .i_wr_data(w_data),
        .i_cmd(w_cmd), .o_status(w_status), .o_valid, .i_stall,
        .o_mean_value, .o_out_row, .o_out_col, .o_neighbour_count,
        .o_last_of_run, .o_end_of_frame
    );
endmodule
`default_nettype wire

// ===== src/nmf_datapath.sv =====
// nmf_datapath: line store, neighbour gather, reciprocal divider and result register
// depends on nmf_pkg
`default_nettype none
module nmf_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [nmf_pkg::ADDR_W-1:0]     i_wr_addr,
    input  wire logic [nmf_pkg::PIXEL_BITS-1:0] i_wr_data,
    input  wire nmf_pkg::t_cmd                  i_cmd,
    output nmf_pkg::t_status                    o_status,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [23:0]                         o_mean_value,
    output logic [11:0]                         o_out_row,
    output logic [4:0]                          o_out_col,
    output logic [3:0]                          o_neighbour_count,
    output logic                                o_last_of_run,
    output logic                                o_end_of_frame
);
    logic [nmf_pkg::PIXEL_BITS-1:0] r_mem [3*nmf_pkg::MAX_COLS];
    logic [nmf_pkg::PIXEL_BITS-1:0] r_rd;
    typedef enum logic [2:0] {S_IDLE, S_RD, S_DIV, S_OUT} t_st;
    t_st r_st;
    logic [3:0] r_k;
    logic [nmf_pkg::SUM_W-1:0] r_sum;
    logic [nmf_pkg::SUM_W-1:0] r_num;
    logic [nmf_pkg::MEAN_W-1:0] r_quo;
    logic [3:0] r_cnt;
    logic r_up, r_dn, r_lf, r_rt, r_rdv;
    logic [nmf_pkg::ROW_W-1:0] r_pr;
    logic [nmf_pkg::COL_W-1:0] r_pc;
    logic [1:0] r_sa, r_sc, r_sb;
    logic r_lst, r_eof;
    logic [1:0] n_slot;
    logic [nmf_pkg::COL_W-1:0] n_col;
    logic n_use;
    logic [nmf_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        n_slot = r_sc;
        n_col = r_pc;
        n_use = 1'b0;
        unique case (r_k)
            4'd0: begin n_slot = r_sa; n_col = r_pc - 1'b1; n_use = r_up & r_lf; end
            4'd1: begin n_slot = r_sa; n_use = r_up; end
            4'd2: begin n_slot = r_sa; n_col = r_pc + 1'b1; n_use = r_up & r_rt; end
            4'd3: begin n_col = r_pc - 1'b1; n_use = r_lf; end
            4'd4: begin n_col = r_pc + 1'b1; n_use = r_rt; end
            4'd5: begin n_slot = r_sb; n_col = r_pc - 1'b1; n_use = r_dn & r_lf; end
            4'd6: begin n_slot = r_sb; n_use = r_dn; end
            4'd7: begin n_slot = r_sb; n_col = r_pc + 1'b1; n_use = r_dn & r_rt; end
            default: ;
        endcase
        // count is 3, 5 or 8; 8 is a plain shift
        unique case (r_cnt)
            4'd3: n_prod = nmf_pkg::PROD_W'(r_num) * nmf_pkg::PROD_W'(nmf_pkg::RECIP3);
            4'd5: n_prod = nmf_pkg::PROD_W'(r_num) * nmf_pkg::PROD_W'(nmf_pkg::RECIP5);
            default: n_prod = nmf_pkg::PROD_W'(r_num) << (nmf_pkg::RECIP_BITS - 3);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[i_wr_addr] <= i_wr_data;
        r_rd <= r_mem[7'(n_slot) * 7'(nmf_pkg::MAX_COLS) + 7'(n_col)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_valid <= 1'b0;
            r_rdv <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_st != S_OUT) o_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_pr <= i_cmd.pr;
                        r_pc <= i_cmd.pc;
                        r_sa <= i_cmd.sa;
                        r_sc <= i_cmd.sc;
                        r_sb <= i_cmd.sb;
                        r_up <= i_cmd.pr != '0;
                        r_dn <= {1'b0, i_cmd.pr} + 1'b1 < i_cmd.rows;
                        r_lf <= i_cmd.pc != '0;
                        r_rt <= {1'b0, i_cmd.pc} + 1'b1 < i_cmd.cols;
                        r_lst <= i_cmd.last;
                        r_eof <= ({1'b0, i_cmd.pr} + 1'b1 == i_cmd.rows)
                            && ({1'b0, i_cmd.pc} + 1'b1 == i_cmd.cols);
                        r_k <= '0;
                        r_sum <= '0;
                        r_cnt <= '0;
                        r_rdv <= 1'b0;
                        r_st <= S_RD;
                    end
                end
                S_RD: begin
                    r_rdv <= n_use;
                    if (r_rdv) begin
                        r_sum <= r_sum + nmf_pkg::SUM_W'(r_rd);
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 4'd8) begin
                        r_num <= r_rdv ? r_sum + nmf_pkg::SUM_W'(r_rd) : r_sum;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo <= n_prod[nmf_pkg::RECIP_SHIFT +: nmf_pkg::MEAN_W];
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1;
                        o_mean_value <= r_quo;
                        o_out_row <= r_pr;
                        o_out_col <= r_pc;
                        o_neighbour_count <= r_cnt;
                        o_last_of_run <= r_lst;
                        o_end_of_frame <= r_eof;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_status.busy = r_st != S_IDLE;
    assign o_status.done = (r_st == S_OUT) && (!o_valid || !i_stall);
endmodule
`default_nettype wire

// ===== src/nmf_ctrl.sv =====
// nmf_ctrl: frame counters, config registers and result sequencing
// depends on nmf_pkg
`default_nettype none
module nmf_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [15:0]                    i_pixel,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_index,
    input  wire logic [12:0]                    i_cfg_data,
    output logic                                o_wr,
    output logic [nmf_pkg::ADDR_W-1:0]          o_wr_addr,
    output logic [nmf_pkg::PIXEL_BITS-1:0]      o_wr_data,
    output nmf_pkg::t_cmd                       o_cmd,
    input  wire nmf_pkg::t_status               i_status
);
    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} t_st;
    t_st r_st;
    logic [12:0] r_rows_reg;
    logic [5:0] r_cols_reg;
    logic [12:0] rows;
    logic [5:0] cols;
    logic [nmf_pkg::ROW_W-1:0] r_row, r_r;
    logic [nmf_pkg::COL_W-1:0] r_col, r_c, r_k;
    logic [1:0] r_slot, r_s;
    logic [1:0] r_phase;
    logic [nmf_pkg::ROW_W-1:0] c_r;
    logic [nmf_pkg::COL_W-1:0] c_c;
    logic c_lastc, c_lastr, r_lastc, r_lastr;
    logic [1:0] s1, s2;
    logic has_b, has_f, more;
    logic [1:0] n_phase;

    function automatic logic [1:0] inc3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    always_comb begin
        rows = (r_rows_reg < 13'd2) ? 13'd2 : (r_rows_reg > 13'd4096) ? 13'd4096 : r_rows_reg;
        cols = (r_cols_reg < 6'd2) ? 6'd2
             : (r_cols_reg > 6'(nmf_pkg::MAX_COLS)) ? 6'(nmf_pkg::MAX_COLS) : r_cols_reg;
        c_r = ({1'b0, r_row} >= rows) ? 12'(rows - 1'b1) : r_row;
        c_c = ({1'b0, r_col} >= cols) ? 5'(cols - 1'b1) : r_col;
        c_lastc = {1'b0, c_c} + 1'b1 == cols;
        c_lastr = {1'b0, c_r} + 1'b1 == rows;
        s1 = inc3(r_s);
        s2 = inc3(s1);
        has_b = (r_r != '0) && r_lastc;
        has_f = r_lastc && r_lastr;
        o_cmd.start = r_st == S_ISSUE;
        o_cmd.rows = rows;
        o_cmd.cols = cols;
        o_cmd.sa = s1;
        o_cmd.sc = s2;
        o_cmd.sb = r_s;
        o_cmd.pr = r_r - 1'b1;
        o_cmd.pc = r_c - 1'b1;
        n_phase = r_phase;
        unique case (r_phase)
            2'd0: begin n_phase = 2'd1; end
            2'd1: begin o_cmd.pc = 5'(cols - 1'b1); n_phase = 2'd2; end
            default: begin
                o_cmd.pr = r_r;
                o_cmd.pc = r_k;
                o_cmd.sa = s2;
                o_cmd.sc = r_s;
            end
        endcase
        unique case (r_phase)
            2'd0: more = has_b || has_f;
            2'd1: more = has_f;
            default: more = {1'b0, r_k} + 1'b1 < cols;
        endcase
        o_cmd.last = !more;
        o_stall = r_st != S_IDLE || i_status.busy;
        o_cfg_ready = 1'b1;
        o_wr = i_valid && !o_stall;
        o_wr_addr = 7'(r_slot) * 7'(nmf_pkg::MAX_COLS) + 7'(c_c);
        o_wr_data = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_row <= '0;
            r_col <= '0;
            r_slot <= '0;
            r_rows_reg <= 13'd2;
            r_cols_reg <= 6'd2;
            r_phase <= '0;
            r_k <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == nmf_pkg::REG_ROWS) r_rows_reg <= i_cfg_data;
                else r_cols_reg <= i_cfg_data[5:0];
            end
            unique case (r_st)
                S_IDLE: begin
                    if (o_wr) begin
                        r_r <= c_r;
                        r_c <= c_c;
                        r_s <= r_slot;
                        r_lastc <= c_lastc;
                        r_lastr <= c_lastr;
                        r_k <= '0;
                        if (c_lastc) begin
                            r_col <= '0;
                            r_row <= c_lastr ? '0 : c_r + 1'b1;
                            r_slot <= c_lastr ? 2'd0 : inc3(r_slot);
                        end else begin
                            r_row <= c_r;
                            r_col <= c_c + 1'b1;
                        end
                        if ((c_r != '0) && (c_c != '0)) begin
                            r_phase <= 2'd0; r_st <= S_ISSUE;
                        end else if ((c_r != '0) && c_lastc) begin
                            r_phase <= 2'd1; r_st <= S_ISSUE;
                        end else if (c_lastc && c_lastr) begin
                            r_phase <= 2'd2; r_st <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: r_st <= S_WAIT;
                S_WAIT: begin
                    if (i_status.done) begin
                        if (!more) r_st <= S_IDLE;
                        else begin
                            r_st <= S_ISSUE;
                            if (r_phase == 2'd2) r_k <= r_k + 1'b1;
                            else if (r_phase == 2'd0 && !has_b) r_phase <= 2'd2;
                            else r_phase <= n_phase;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
